[sv/rtpd_pkg.sv]
// package for the rtp h.264/h.265 depacketizer
// packet kinds, sequencer states and default sizes; no dependencies
package rtpd_pkg;
   localparam int FRAG_BYTES_DEF = 65536;
   localparam int OUT_BYTES_DEF  = 131072;

   typedef enum logic [1:0] {
      KIND_IGNORE = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_AGG    = 2'd2,
      KIND_FRAG   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_COPY_RD,
      ST_COPY,
      ST_PULL,
      ST_RESP
   } state_type;
endpackage

[sv/rtpd_if.sv]
// valid/ready channel interfaces for the depacketizer
// request and response payloads; no dependencies
interface rtpd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic [15:0] pkt_len;
   modport source (output valid, req_type, data_byte, first_byte, pkt_len, input ready);
   modport sink (input valid, req_type, data_byte, first_byte, pkt_len, output ready);
endinterface

interface rtpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_valid;
   logic [7:0]  out_byte;
   logic [17:0] queue_level;
   logic        overflow;
   modport source (output valid, out_valid, out_byte, queue_level, overflow, input ready);
   modport sink (input valid, out_valid, out_byte, queue_level, overflow, output ready);
endinterface

[sv/rtp_h264_h265_depacketizer.sv]
// RTP H.264/H.265 depacketizer top level with fragment store and output queue
// depends on rtpd_pkg and the channel interfaces in rtpd_if
//
// One request is taken at a time. A pull reads the queue in ST_PULL and gives its
// result from ST_RESP; a push passes through ST_EMIT to ST_RESP. The next request is
// taken in the cycle after the response transfer. A push emits its bytes into the
// queue one per cycle: a single-NAL first byte emits 5, an aggregate size field 4
// start-code bytes, each later single-NAL byte and each aggregated unit byte 1. An
// H.265 start fragment also writes the second header byte into the store. The last
// byte of an end fragment adds the start code and a copy of the fragment store into
// the queue, each store byte taking a read state and a write state. Both stores have
// one write port and one registered read port; no clearing pass is needed after
// reset.
module rtp_h264_h265_depacketizer #(
   parameter int FRAG_BYTES = rtpd_pkg::FRAG_BYTES_DEF,
   parameter int OUT_BYTES  = rtpd_pkg::OUT_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   rtpd_req_if.sink   req,
   rtpd_rsp_if.source rsp,
   input  logic csr_write_en,
   input  logic csr_write_data
);
   import rtpd_pkg::*;

   localparam int FW = $clog2(FRAG_BYTES);
   localparam int FC = $clog2(FRAG_BYTES + 1);
   localparam int OW = $clog2(OUT_BYTES);
   localparam int OC = $clog2(OUT_BYTES + 1);

   logic [7:0] frag_mem [FRAG_BYTES];
   logic [7:0] out_mem  [OUT_BYTES];

   logic        codec_ff;
   state_type   st_ff, st_in;
   kind_type    kind_ff, kind_in;
   logic [FC-1:0] fill_ff, fill_in;
   logic        fact_ff, fact_in;
   logic [5:0]  fnk_ff, fnk_in;
   logic [OW-1:0] head_ff, head_in;
   logic [OC-1:0] cnt_ff, cnt_in;
   logic [15:0] idx_ff, idx_in, len_ff, len_in;
   logic [7:0]  h1_ff, h1_in, h2_ff, h2_in;
   logic [15:0] arem_ff, arem_in;
   logic [1:0]  aph_ff, aph_in;
   // pending emission: up to 4 start-code bytes, then optional data byte
   logic [2:0]  sc_ff, sc_in;
   logic        ed_ff, ed_in;
   logic [7:0]  eb_ff, eb_in;
   logic        copy_ff, copy_in;
   logic [FC-1:0] ci_ff, ci_in;
   logic        ov_ff, ov_in;
   logic        ovl_ff, ovl_in;
   logic        rv_ff, rv_in;
   logic [7:0]  rb_ff;
   logic        pv_ff, pv_in;
   logic        rsp_v_ff, rsp_v_in;

   // memory ports
   logic          fw_en;
   logic [FW-1:0] fw_addr;
   logic [7:0]    fw_data;
   logic [FW-1:0] fr_addr;
   logic [7:0]    fr_q;
   logic          ow_en;
   logic [7:0]    ow_data;
   logic [7:0]    oq_q;
   logic [OW-1:0] ow_addr;
   logic [OC:0]   osum;

   always_ff @(posedge clock) begin
      if (fw_en) frag_mem[fw_addr] <= fw_data;
      fr_q <= frag_mem[fr_addr];
   end

   always_ff @(posedge clock) begin
      if (ow_en) out_mem[ow_addr] <= ow_data;
      oq_q <= out_mem[head_ff];
   end

   always_comb begin
      osum = {1'b0, cnt_ff} + {{(OC + 1 - OW){1'b0}}, head_ff};
      if (osum >= (OC + 1)'(OUT_BYTES)) osum = osum - (OC + 1)'(OUT_BYTES);
      ow_addr = osum[OW-1:0];
   end

   assign req.ready       = (st_ff == ST_IDLE) && !rsp_v_ff;
   assign rsp.valid       = rsp_v_ff;
   assign rsp.out_valid   = rv_ff;
   assign rsp.out_byte    = rv_ff ? rb_ff : 8'd0;
   assign rsp.queue_level = 18'(cnt_ff);
   assign rsp.overflow    = ovl_ff;

   // push and pull sequencer
   always_comb begin
      logic [7:0]  b;
      logic [15:0] p, l;
      logic [5:0]  t;
      logic [16:0] sz17;
      logic [15:0] sz;
      logic        fin;
      logic [16:0] p1;
      logic [FC:0] tot;
      b = req.data_byte;
      st_in = st_ff; kind_in = kind_ff; fill_in = fill_ff; fact_in = fact_ff;
      fnk_in = fnk_ff; head_in = head_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      len_in = len_ff; h1_in = h1_ff; h2_in = h2_ff; arem_in = arem_ff;
      aph_in = aph_ff; sc_in = sc_ff; ed_in = ed_ff; eb_in = eb_ff;
      copy_in = copy_ff; ci_in = ci_ff; ov_in = ov_ff; ovl_in = ovl_ff;
      rv_in = rv_ff; pv_in = 1'b0; rsp_v_in = rsp_v_ff;
      fw_en = 1'b0; fw_addr = fill_ff[FW-1:0]; fw_data = b;
      fr_addr = ci_ff[FW-1:0];
      ow_en = 1'b0; ow_data = 8'd0;
      p = 16'd0; l = 16'd0; t = 6'd0; sz = 16'd0; sz17 = 17'd0; fin = 1'b0;
      p1 = 17'd0; tot = '0;
      if (rsp_v_ff && rsp.ready) rsp_v_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               ov_in = 1'b0; sc_in = 3'd0; ed_in = 1'b0; copy_in = 1'b0;
               if (req.req_type) begin
                  st_in = ST_PULL;
               end else begin
                  st_in = ST_EMIT;
                  l = req.first_byte ? req.pkt_len : len_ff;
                  p = req.first_byte ? 16'd0 : idx_ff;
                  len_in = l; idx_in = p;
                  if (p < l) begin
                     idx_in = p + 16'd1;
                     p1 = {1'b0, p} + 17'd1;
                     if (p == 16'd0) begin
                        kind_in = KIND_IGNORE; aph_in = 2'd0; arem_in = 16'd0;
                        if (!codec_ff) begin
                           t = {1'b0, b[4:0]};
                           if (t >= 6'd1 && t <= 6'd23) begin
                              kind_in = KIND_SINGLE; sc_in = 3'd4; ed_in = 1'b1; eb_in = b;
                           end else if (t == 6'd24) begin
                              kind_in = KIND_AGG;
                           end else if (t == 6'd28) begin
                              fin = 1'b1;
                           end
                        end else if (l >= 16'd2) begin
                           t = b[6:1];
                           if (t < 6'd48) begin
                              kind_in = KIND_SINGLE; sc_in = 3'd4; ed_in = 1'b1; eb_in = b;
                           end else if (t == 6'd48) begin
                              kind_in = KIND_AGG;
                           end else if (t == 6'd49) begin
                              fin = 1'b1;
                           end
                        end
                        if (fin && l >= (codec_ff ? 16'd3 : 16'd2)) begin
                           tot = {1'b0, fill_ff} + (FC + 1)'(l);
                           if (tot > (FC + 1)'(FRAG_BYTES)) begin
                              fact_in = 1'b0; fill_in = '0;
                           end else begin
                              h1_in = b; kind_in = KIND_FRAG;
                           end
                        end
                     end else if (kind_ff == KIND_SINGLE) begin
                        ed_in = 1'b1; eb_in = b;
                     end else if (kind_ff == KIND_AGG) begin
                        if (p >= (codec_ff ? 16'd2 : 16'd1)) begin
                           case (aph_ff)
                              2'd0: begin
                                 if (p1 + 17'd1 > {1'b0, l}) aph_in = 2'd3;
                                 else begin arem_in = {8'd0, b}; aph_in = 2'd1; end
                              end
                              2'd1: begin
                                 sz = {arem_ff[7:0], b};
                                 sz17 = {1'b0, sz};
                                 if (p1 + sz17 > {1'b0, l}) aph_in = 2'd3;
                                 else begin
                                    sc_in = 3'd4; arem_in = sz;
                                    aph_in = (sz != 16'd0) ? 2'd2 : 2'd0;
                                 end
                              end
                              2'd2: begin
                                 ed_in = 1'b1; eb_in = b;
                                 arem_in = arem_ff - 16'd1;
                                 if (arem_ff == 16'd1) aph_in = 2'd0;
                              end
                              default: ;
                           endcase
                        end
                     end else if (kind_ff == KIND_FRAG) begin
                        if (p < (codec_ff ? 16'd2 : 16'd1)) begin
                           h2_in = b;
                        end else begin
                           fin = 1'b1;
                           if (p == (codec_ff ? 16'd2 : 16'd1)) begin
                              t = codec_ff ? b[5:0] : {1'b0, b[4:0]};
                              if (b[7]) begin
                                 // start fragment: write rebuilt header
                                 fw_en = 1'b1; fw_addr = '0;
                                 if (codec_ff) begin
                                    fw_data = {h1_ff[7], t, h1_ff[0]};
                                    ed_in = 1'b1; eb_in = h2_ff;
                                    fill_in = FC'(1);
                                 end else begin
                                    fw_data = {h1_ff[7:5], t[4:0]};
                                    fill_in = FC'(1);
                                 end
                              end
                              if (!((b[7] || fact_ff) && (b[7] || fnk_ff == t))) begin
                                 fact_in = 1'b0; kind_in = KIND_IGNORE; fin = 1'b0;
                              end else begin
                                 fact_in = 1'b1; fnk_in = t; h2_in = b;
                              end
                           end else if (fill_ff < FC'(FRAG_BYTES)) begin
                              fw_en = 1'b1; fill_in = fill_ff + FC'(1);
                           end
                           if (fin && p1 == {1'b0, l} && h2_in[6]) begin
                              copy_in = 1'b1; sc_in = 3'd4;
                           end
                        end
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            // second header byte of an h.265 start fragment goes to the store
            if (ed_ff && kind_ff == KIND_FRAG) begin
               fw_en = 1'b1; fw_addr = FW'(1); fw_data = eb_ff;
               fill_in = FC'(2); ed_in = 1'b0;
            end else if (sc_ff != 3'd0 || ed_ff) begin
               ow_data = (sc_ff == 3'd1) ? 8'h01 : (sc_ff != 3'd0 ? 8'h00 : eb_ff);
               if (cnt_ff >= OC'(OUT_BYTES)) ov_in = 1'b1;
               else begin ow_en = 1'b1; cnt_in = cnt_ff + OC'(1); end
               if (sc_ff != 3'd0) sc_in = sc_ff - 3'd1; else ed_in = 1'b0;
            end else if (copy_ff) begin
               ci_in = '0; st_in = ST_COPY_RD;
            end else begin
               st_in = ST_RESP; rv_in = 1'b0;
            end
         end
         ST_COPY_RD: begin
            if (ci_ff >= fill_ff) begin
               fill_in = '0; fact_in = 1'b0; copy_in = 1'b0;
               st_in = ST_RESP; rv_in = 1'b0;
            end else st_in = ST_COPY;
         end
         ST_COPY: begin
            ow_data = fr_q;
            if (cnt_ff >= OC'(OUT_BYTES)) ov_in = 1'b1;
            else begin ow_en = 1'b1; cnt_in = cnt_ff + OC'(1); end
            ci_in = ci_ff + FC'(1);
            fr_addr = ci_in[FW-1:0];
            st_in = ST_COPY_RD;
         end
         ST_PULL: begin
            pv_in = 1'b1;
            rv_in = cnt_ff != '0;
            st_in = ST_RESP;
         end
         ST_RESP: begin
            ovl_in = ov_ff; rsp_v_in = 1'b1; st_in = ST_IDLE;
            if (pv_ff && rv_ff) begin
               head_in = (head_ff == OW'(OUT_BYTES - 1)) ? '0 : head_ff + OW'(1);
               cnt_in = cnt_ff - OC'(1);
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // pulled byte capture
   always_ff @(posedge clock) begin
      if (st_ff == ST_RESP && pv_ff) rb_ff <= oq_q;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff <= 1'b0; st_ff <= ST_IDLE; kind_ff <= KIND_IGNORE;
         fill_ff <= '0; fact_ff <= 1'b0; fnk_ff <= 6'd0; head_ff <= '0;
         cnt_ff <= '0; idx_ff <= 16'd0; len_ff <= 16'd0; h1_ff <= 8'd0;
         h2_ff <= 8'd0; arem_ff <= 16'd0; aph_ff <= 2'd0; sc_ff <= 3'd0;
         ed_ff <= 1'b0; eb_ff <= 8'd0; copy_ff <= 1'b0; ci_ff <= '0;
         ov_ff <= 1'b0; ovl_ff <= 1'b0; rv_ff <= 1'b0; pv_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (csr_write_en) codec_ff <= csr_write_data;
         st_ff <= st_in; kind_ff <= kind_in; fill_ff <= fill_in;
         fact_ff <= fact_in; fnk_ff <= fnk_in; head_ff <= head_in;
         cnt_ff <= cnt_in; idx_ff <= idx_in; len_ff <= len_in; h1_ff <= h1_in;
         h2_ff <= h2_in; arem_ff <= arem_in; aph_ff <= aph_in; sc_ff <= sc_in;
         ed_ff <= ed_in; eb_ff <= eb_in; copy_ff <= copy_in; ci_ff <= ci_in;
         ov_ff <= ov_in; ovl_ff <= ovl_in; rv_ff <= rv_in;
         pv_ff <= (st_ff == ST_RESP) ? 1'b0 : (pv_in | pv_ff);
         rsp_v_ff <= rsp_v_in;
      end
   end
endmodule
